### rtl/assert_macros.svh
// Assertion macros shared by the route lookup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define IPRL_ASSERT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IPRL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IPRL_ASSERT(name, clk, rst_n, ante, cons)
`define IPRL_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

### rtl/iprl_pkg.sv
// Types, constants and field offsets of the IPv4 route lookup core.
package iprl_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int IP_W   = 32;
    localparam int PLEN_W = 6;
    localparam int TTL_W  = 8;

    localparam int NET_LSB  = 0;
    localparam int MASK_LSB = NET_LSB + IP_W;
    localparam int PLEN_LSB = MASK_LSB + IP_W;
    localparam int DIR_LSB  = PLEN_LSB + PLEN_W;
    localparam int NHOP_LSB = DIR_LSB + 1;
    localparam int DST_LSB  = NHOP_LSB + IP_W;
    localparam int TTL_LSB  = DST_LSB + IP_W;
    localparam int IN_BITS  = TTL_LSB + TTL_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    typedef enum logic
    {
        OP_ADD = 1'b0,
        OP_FWD = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        VERDICT_TTL_EXPIRED = 2'd0,
        VERDICT_DIRECT      = 2'd1,
        VERDICT_INDIRECT    = 2'd2,
        VERDICT_NO_ROUTE    = 2'd3
    } verdict_t;

    typedef struct packed
    {
        logic [IP_W-1:0]   gateway;
        logic              direct;
        logic [PLEN_W-1:0] prefix_len;
        logic [IP_W-1:0]   mask;
        logic [IP_W-1:0]   network;
    } route_entry_t;

    localparam int ENTRY_W = $bits(route_entry_t);

    typedef struct packed
    {
        logic             start;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             load;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic out_free;
    } dp_status_t;

endpackage

### rtl/iprl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iprl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/iprl_ctrl.sv
// Controller: input handshake, route count and table scan sequencing.
`include "assert_macros.svh"

module iprl_ctrl
    import iprl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  op_t              in_op,
    input  logic [TTL_W-1:0] in_ttl,
    output ctrl_cmd_t        cmd,
    input  dp_status_t       status
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic accept;
    logic full;
    logic last_idx;

    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));
    assign last_idx = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        cmd.start    = 1'b0;
        cmd.wr_en    = 1'b0;
        cmd.wr_addr  = count_reg[IDX_W-1:0];
        cmd.rd_en    = 1'b0;
        cmd.rd_addr  = idx_reg;
        cmd.load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_ADD)
                    begin
                        if (!full)
                        begin
                            cmd.wr_en  = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        cmd.start = 1'b1;
                        idx_next  = '0;
                        if (in_ttl == '0 || count_reg == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (last_idx)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_TAIL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    `IPRL_ASSERT_NEXT(a_full_add_ignored, clk, rst_n, accept && in_op == OP_ADD && full, full)
    `IPRL_ASSERT(a_scan_in_range, clk, rst_n, state_reg == ST_SCAN, CNT_W'(idx_reg) < count_reg)
    `IPRL_ASSERT(a_load_when_free, clk, rst_n, cmd.load, status.out_free)

endmodule

### rtl/iprl_dp.sv
// Datapath: route table RAM, match evaluation, best-route tracking and result register.
`include "assert_macros.svh"

module iprl_dp
    import iprl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IN_DATA_W-1:0] in_data,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output verdict_t             out_verdict,
    output logic [IP_W-1:0]      out_gateway
);

    route_entry_t wr_entry;
    route_entry_t rd_entry;

    logic [IP_W-1:0]   dst_reg;
    logic              ttl_zero_reg;
    logic              eval_reg;
    logic              direct_hit_reg;
    logic [PLEN_W-1:0] best_len_reg;
    logic [IP_W-1:0]   best_hop_reg;
    logic              m_valid_reg;
    verdict_t          m_verdict_reg;
    logic [IP_W-1:0]   m_hop_reg;

    logic     match;
    verdict_t verdict;
    logic [IP_W-1:0] hop;

    assign wr_entry.network    = in_data[NET_LSB +: IP_W];
    assign wr_entry.mask       = in_data[MASK_LSB +: IP_W];
    assign wr_entry.prefix_len = in_data[PLEN_LSB +: PLEN_W];
    assign wr_entry.direct     = in_data[DIR_LSB];
    assign wr_entry.gateway    = in_data[NHOP_LSB +: IP_W];

    iprl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (cmd.wr_addr),
        .wdata (wr_entry),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (rd_entry)
    );

    assign match = (rd_entry.network == (dst_reg & rd_entry.mask));

    always_comb
    begin
        hop = '0;
        if (ttl_zero_reg)
        begin
            verdict = VERDICT_TTL_EXPIRED;
        end
        else if (direct_hit_reg)
        begin
            verdict = VERDICT_DIRECT;
        end
        else if (best_len_reg != '0)
        begin
            verdict = VERDICT_INDIRECT;
            hop     = best_hop_reg;
        end
        else
        begin
            verdict = VERDICT_NO_ROUTE;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            eval_reg <= cmd.rd_en;
            if (cmd.load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dst_reg        <= in_data[DST_LSB +: IP_W];
            ttl_zero_reg   <= (in_data[TTL_LSB +: TTL_W] == '0);
            direct_hit_reg <= 1'b0;
            best_len_reg   <= '0;
            best_hop_reg   <= '0;
        end
        else if (eval_reg && match)
        begin
            if (rd_entry.direct)
            begin
                direct_hit_reg <= 1'b1;
            end
            if (rd_entry.prefix_len > best_len_reg)
            begin
                best_len_reg <= rd_entry.prefix_len;
                best_hop_reg <= rd_entry.gateway;
            end
        end
        if (cmd.load)
        begin
            m_verdict_reg <= verdict;
            m_hop_reg     <= hop;
        end
    end

    assign status.out_free = !m_valid_reg || out_ready;
    assign out_valid       = m_valid_reg;
    assign out_verdict     = m_verdict_reg;
    assign out_gateway     = m_hop_reg;

    `IPRL_ASSERT(a_hop_zero, clk, rst_n, m_valid_reg && m_verdict_reg != VERDICT_INDIRECT, m_hop_reg == '0)
    `IPRL_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, cmd.load, m_valid_reg)
    `IPRL_ASSERT_NEXT(a_out_held, clk, rst_n, m_valid_reg && !out_ready, m_valid_reg)

endmodule

### rtl/ipv4_route_lookup_core.sv
// Top level of the IPv4 route lookup core.
// An add word (tuser 0) appends one route to a table of TABLE_DEPTH entries;
// it is dropped once the table is full and yields no result.
// A forward word (tuser 1) yields one result. It scans every stored route,
// as the single read port of the route RAM delivers one entry per cycle to
// the match logic, and skips the scan when its TTL is zero or the table is
// empty. A finished result sits in an output register, so the core takes
// its next word while that result waits on m_axis_tready.
module ipv4_route_lookup_core
    import iprl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // route_network, route_mask, route_prefix_len, route_is_direct,
    // route_next_hop, packet_dst_addr, packet_ttl, zero pad
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // command
    input  logic [0:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // next_hop_addr
    output logic [IP_W-1:0]      m_axis_tdata,
    // verdict
    output logic [1:0]           m_axis_tuser
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    verdict_t   verdict;

    iprl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (op_t'(s_axis_tuser[0])),
        .in_ttl   (s_axis_tdata[TTL_LSB +: TTL_W]),
        .cmd      (cmd),
        .status   (status)
    );

    iprl_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (s_axis_tdata),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_verdict (verdict),
        .out_gateway (m_axis_tdata)
    );

    assign m_axis_tuser = verdict;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the IPv4 route lookup core: route adds and packet lookups.
module testbench
    import iprl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct
    {
        verdict_t        verdict;
        bit [IP_W-1:0]   gateway;
    } lookup_result_t;

    class route_scoreboard;
        bit [IP_W-1:0]   rt_net[TABLE_DEPTH];
        bit [IP_W-1:0]   rt_mask[TABLE_DEPTH];
        bit [PLEN_W-1:0] rt_plen[TABLE_DEPTH];
        bit              rt_direct[TABLE_DEPTH];
        bit [IP_W-1:0]   rt_hop[TABLE_DEPTH];
        int              route_count;
        lookup_result_t  pending_verdicts[$];
        int              failures;

        function new();
            route_count = 0;
            failures = 0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        function lookup_result_t lookup_route(bit [IP_W-1:0] dst, bit [TTL_W-1:0] ttl);
            lookup_result_t res;
            bit [PLEN_W-1:0] best_len;
            bit              direct_hit;
            int              i;
            res.verdict = VERDICT_NO_ROUTE;
            res.gateway = '0;
            best_len = '0;
            direct_hit = 1'b0;
            if (ttl == 0)
            begin
                res.verdict = VERDICT_TTL_EXPIRED;
                return res;
            end
            for (i = 0; i < route_count && !direct_hit; i++)
                if (rt_direct[i] && rt_net[i] == (dst & rt_mask[i]))
                    direct_hit = 1'b1;
            if (direct_hit)
            begin
                res.verdict = VERDICT_DIRECT;
                return res;
            end
            for (i = 0; i < route_count; i++)
                if (rt_plen[i] > best_len && rt_net[i] == (dst & rt_mask[i]))
                begin
                    best_len = rt_plen[i];
                    res.gateway = rt_hop[i];
                end
            if (best_len != 0)
                res.verdict = VERDICT_INDIRECT;
            else
                res.gateway = '0;
            return res;
        endfunction

        function void note_word(op_t op, bit [IN_DATA_W-1:0] w);
            if (op == OP_ADD)
            begin
                if (route_count < TABLE_DEPTH)
                begin
                    rt_net[route_count]    = w[NET_LSB +: IP_W];
                    rt_mask[route_count]   = w[MASK_LSB +: IP_W];
                    rt_plen[route_count]   = w[PLEN_LSB +: PLEN_W];
                    rt_direct[route_count] = w[DIR_LSB];
                    rt_hop[route_count]    = w[NHOP_LSB +: IP_W];
                    route_count++;
                end
            end
            else
                pending_verdicts.push_back(lookup_route(w[DST_LSB +: IP_W], w[TTL_LSB +: TTL_W]));
        endfunction

        function void check_result(logic [1:0] verdict, logic [IP_W-1:0] hop);
            lookup_result_t want;
            if (pending_verdicts.size() == 0)
            begin
                flag($sformatf("unexpected result: verdict %0d hop %h", verdict, hop));
                return;
            end
            want = pending_verdicts.pop_front();
            if (verdict !== want.verdict || hop !== want.gateway)
                flag($sformatf("mismatch: verdict exp %s got %0d, hop exp %h got %h",
                               want.verdict.name(), verdict, want.gateway, hop));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [0:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [IP_W-1:0]      m_axis_tdata;
    logic [1:0]           m_axis_tuser;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  recv_hold = 1'b0;
    bit  hold_start = 1'b0;

    bit [IP_W-1:0] known_nets[$];
    bit [IP_W-1:0] known_masks[$];

    route_scoreboard lpm_sb = new();

    ipv4_route_lookup_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
        m_axis_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                lpm_sb.note_word(op_t'(s_axis_tuser[0]), s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                lpm_sb.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    // long receiver hold-off so the core fills up and back-pressures its input
    initial
    begin
        wait (hold_start);
        recv_hold = 1'b1;
        repeat (400) @(posedge clk);
        recv_hold = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit [IN_DATA_W-1:0] pack_word(bit [IP_W-1:0] net, bit [IP_W-1:0] mask,
                                                     bit [PLEN_W-1:0] plen, bit dir,
                                                     bit [IP_W-1:0] hop, bit [IP_W-1:0] dst,
                                                     bit [TTL_W-1:0] ttl);
        bit [IN_DATA_W-1:0] w;
        w = '0;
        w[NET_LSB +: IP_W]    = net;
        w[MASK_LSB +: IP_W]   = mask;
        w[PLEN_LSB +: PLEN_W] = plen;
        w[DIR_LSB]            = dir;
        w[NHOP_LSB +: IP_W]   = hop;
        w[DST_LSB +: IP_W]    = dst;
        w[TTL_LSB +: TTL_W]   = ttl;
        return w;
    endfunction

    function automatic bit [IP_W-1:0] prefix_mask(int plen);
        if (plen == 0)
            return '0;
        if (plen >= IP_W)
            return '1;
        return ~(32'hFFFF_FFFF >> plen);
    endfunction

    task automatic send_word(op_t op, bit [IN_DATA_W-1:0] w);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic add_route(bit [IP_W-1:0] net, bit [IP_W-1:0] mask, bit [PLEN_W-1:0] plen,
                             bit dir, bit [IP_W-1:0] hop);
        if (known_nets.size() < TABLE_DEPTH)
        begin
            known_nets.push_back(net);
            known_masks.push_back(mask);
        end
        send_word(OP_ADD, pack_word(net, mask, plen, dir, hop, $urandom, TTL_W'($urandom)));
    endtask

    task automatic forward(bit [IP_W-1:0] dst, bit [TTL_W-1:0] ttl);
        send_word(OP_FWD, pack_word($urandom, $urandom, PLEN_W'($urandom_range(0, 63)),
                                    1'($urandom_range(0, 1)), $urandom, dst, ttl));
    endtask

    task automatic random_add();
        bit [IP_W-1:0] net;
        bit [IP_W-1:0] mask;
        bit [IP_W-1:0] base;
        bit [IP_W-1:0] base_mask;
        int            plen;
        int            k;
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 32);
        mask = ($urandom_range(0, 9) == 0) ? $urandom : prefix_mask(plen);
        if (known_nets.size() != 0 && $urandom_range(0, 99) < 60)
        begin
            k = $urandom_range(0, known_nets.size() - 1);
            base = known_nets[k];
            base_mask = known_masks[k];
        end
        else
        begin
            base = $urandom;
            base_mask = '0;
        end
        net = (base | ($urandom & ~base_mask)) & mask;
        if ($urandom_range(0, 9) == 0)
            net = $urandom;
        add_route(net, mask, PLEN_W'(plen), $urandom_range(0, 99) < 12, $urandom);
    endtask

    task automatic random_lookup();
        bit [IP_W-1:0]  dst;
        bit [TTL_W-1:0] ttl;
        int             k;
        dst = $urandom;
        if (known_nets.size() != 0 && $urandom_range(0, 99) < 80)
        begin
            k = $urandom_range(0, known_nets.size() - 1);
            dst = (known_nets[k] & known_masks[k]) | (dst & ~known_masks[k]);
        end
        ttl = ($urandom_range(0, 11) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        forward(dst, ttl);
    endtask

    initial
    begin
        int n;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table, then a zero-length default route that must never win
        forward(32'hC0A8_0101, 8'd1);
        forward(32'hC0A8_0101, 8'd0);
        add_route(32'h0000_0000, 32'h0000_0000, 6'd0, 1'b0, 32'h0101_0101);
        forward(32'hFFFF_FFFF, 8'hFF);
        forward(32'h0000_0000, 8'hFF);
        // nested prefixes and an equal-length tie
        add_route(32'hC0A8_0000, 32'hFFFF_0000, 6'd16, 1'b0, 32'h0A00_0010);
        add_route(32'hC0A8_0100, 32'hFFFF_FF00, 6'd24, 1'b0, 32'h0A00_0018);
        add_route(32'hC0A8_0100, 32'hFFFF_FF00, 6'd24, 1'b0, 32'h0A00_0019);
        forward(32'hC0A8_0105, 8'd64);
        forward(32'hC0A8_FF01, 8'd64);
        // prefix length above 32
        add_route(32'h0A00_0000, 32'hFF00_0000, 6'd63, 1'b0, 32'h0A00_003F);
        forward(32'h0A12_3456, 8'd2);
        add_route(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd32, 1'b0, 32'hFFFF_FFFF);
        forward(32'hFFFF_FFFF, 8'd128);
        // direct entry overrides a longer indirect match
        add_route(32'hC0A8_0100, 32'hFFFF_FF00, 6'd8, 1'b1, 32'hFFFF_FFFF);
        forward(32'hC0A8_0177, 8'd1);
        forward(32'hC0A8_0177, 8'd0);
        // network not aligned to its mask never matches
        add_route(32'hFFFF_FFFF, 32'h0000_0000, 6'd63, 1'b1, 32'h0000_0000);
        forward(32'h7F00_0001, 8'hFF);
        forward(32'hC0A8_0234, 8'd7);

        for (n = 0; n < 630; n++)
        begin
            case ((n / 80) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            if (n == 330)
                hold_start = 1'b1;
            if ($urandom_range(0, 99) < 12)
                random_add();
            else
                random_lookup();
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (lpm_sb.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (lpm_sb.failures == 0 && lpm_sb.pending_verdicts.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/iprl_pkg.sv
rtl/iprl_ram.sv
rtl/iprl_ctrl.sv
rtl/iprl_dp.sv
rtl/ipv4_route_lookup_core.sv
tb/sv/testbench.sv
